>>> sv/two_player_game_clock_unit_macros.svh
`ifndef TWO_PLAYER_GAME_CLOCK_UNIT_MACROS_SVH
`define TWO_PLAYER_GAME_CLOCK_UNIT_MACROS_SVH

// Check that cons holds in the same cycle as ante; quiet while rst is high
`define TPGC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante; quiet while rst is high
`define TPGC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/tpgc_pkg.sv
package tpgc_pkg;

  // Field widths
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned GUARD_W  = 16;
  localparam int unsigned DIGITS_W = 14;

  // Request codes on req_type
  localparam logic [2:0] REQ_TICK   = 3'd0;
  localparam logic [2:0] REQ_RESET  = 3'd1;
  localparam logic [2:0] REQ_SET    = 3'd2;
  localparam logic [2:0] REQ_PAUSE  = 3'd3;
  localparam logic [2:0] REQ_RESUME = 3'd4;

  // Display actions
  localparam logic [1:0] DISP_LEAVE = 2'd0;
  localparam logic [1:0] DISP_SHOW  = 2'd1;
  localparam logic [1:0] DISP_BLANK = 2'd2;

  // Timing constants
  localparam int unsigned REPORT_INTERVAL_MS = 1000;
  localparam int unsigned BLINK_HALF_MS      = 500;
  localparam int unsigned MS_PER_SEC         = 1000;
  localparam int unsigned MS_PER_MIN         = 60000;
  localparam int unsigned SEC_PER_MIN        = 60;
  localparam int unsigned MAX_MINUTES        = 99;
  localparam int unsigned DIGITS_PER_MIN     = 100;

  localparam logic [GUARD_W-1:0] PAUSE_GUARD_RESET = 16'd200;

  // Digit field widths and typed constants
  localparam int unsigned SEC_W = $clog2(SEC_PER_MIN);
  localparam int unsigned MIN_W = $clog2(MAX_MINUTES + 1);
  localparam logic [MIN_W-1:0]    MAX_MINUTES_V    = MIN_W'(MAX_MINUTES);
  localparam logic [DIGITS_W-1:0] DIGITS_PER_MIN_V = DIGITS_W'(DIGITS_PER_MIN);
  localparam logic [TIME_W-1:0]   REPORT_INTERVAL_V = TIME_W'(REPORT_INTERVAL_MS);

  // Queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam logic [QPTR_W:0]   QCOUNT_FULL = (QPTR_W + 1)'(QUEUE_DEPTH);
  localparam logic [QPTR_W-1:0] QPTR_LAST   = QPTR_W'(QUEUE_DEPTH - 1);

  // Floor of log2, evaluated at elaboration only
  function automatic int unsigned floor_log2(int unsigned v);
    int unsigned r;
    r = 0;
    for (int i = 1; i < 32; i++) begin
      if ((v >> i) != 0) r = i;
    end
    return r;
  endfunction

  // Reciprocals for division by constants: q_est = (n * MAGIC) >> (32 + SH),
  // which is either the true quotient or one short of it
  localparam int unsigned REPORT_SH = floor_log2(REPORT_INTERVAL_MS);
  localparam logic [63:0] REPORT_MAGIC =
    (64'd1 << (32 + REPORT_SH)) / 64'(REPORT_INTERVAL_MS);
  localparam int unsigned BLINK_SH = floor_log2(BLINK_HALF_MS);
  localparam logic [63:0] BLINK_MAGIC =
    (64'd1 << (32 + BLINK_SH)) / 64'(BLINK_HALF_MS);
  localparam int unsigned SEC_SH = floor_log2(MS_PER_SEC);
  localparam logic [63:0] SEC_MAGIC =
    (64'd1 << (32 + SEC_SH)) / 64'(MS_PER_SEC);
  localparam int unsigned MIN_SH = floor_log2(MS_PER_MIN);
  localparam logic [63:0] MIN_MAGIC =
    (64'd1 << (32 + MIN_SH)) / 64'(MS_PER_MIN);

  // Quotient estimate from the registered reciprocal product
  function automatic logic [TIME_W-1:0] cdiv_est(logic [63:0] prod, int unsigned sh);
    return prod[63:32] >> sh;
  endfunction

  // Estimate times divisor; never exceeds the dividend, so 32 bits suffice
  function automatic logic [TIME_W-1:0] cdiv_back(logic [TIME_W-1:0] q, int unsigned d);
    return q * TIME_W'(d);
  endfunction

  // High when the estimate fell one short of the true quotient
  function automatic logic cdiv_short(logic [TIME_W-1:0] n, logic [TIME_W-1:0] qd,
                                      int unsigned d);
    return (n - qd) >= TIME_W'(d);
  endfunction

  // Item class decided by the front
  typedef enum logic [5:0] {
    KIND_TICK   = 6'b000001,
    KIND_RESET  = 6'b000010,
    KIND_SET    = 6'b000100,
    KIND_PAUSE  = 6'b001000,
    KIND_RESUME = 6'b010000,
    KIND_OTHER  = 6'b100000
  } kind_t;

  // Classified item as queued for the back
  typedef struct packed {
    kind_t             kind;
    logic [TIME_W-1:0] now_ms;
    logic [TIME_W-1:0] mark_ms;    // now_ms rounded down to the report interval
    logic              blink_odd;  // odd blink half period
    logic              pause_level;
    logic              white_level;
    logic              black_level;
    logic [TIME_W-1:0] val_a;      // reset: base time, set: new white time
    logic [TIME_W-1:0] val_b;      // reset: increment, set: new black time
    logic              write_a;
    logic              write_b;
  } item_t;

  // State after one item, before digit conversion
  typedef struct packed {
    logic [TIME_W-1:0] white_left_ms;
    logic [TIME_W-1:0] black_left_ms;
    logic              black_to_move;
    logic              is_paused;
    logic              is_running;
    logic              acknowledged;
    logic              state_report;
    logic              button_report;
    logic [1:0]        display_action;
  } result_t;

endpackage

>>> sv/two_player_game_clock_unit.sv
// Two-sided game clock with per-move increment, driven by millisecond stamps.
// Input channel (in_valid / in_stall): one item per tick sample or command;
// an item is taken at a rising edge with in_valid high and in_stall low.
// Output channel (out_valid / out_stall): exactly one result item per input
// item, in order; taken at a rising edge with out_valid high, out_stall low.
// Configuration: cfg_we with cfg_wdata writes the pause guard in milliseconds;
// write it only while no item is in flight.
// Pipeline: the item passes eight registers (two front stages for the report
// and blink dividers, the queue, the state update, three stages for the
// minute and second dividers and the output register), the first loaded at
// the edge that takes the item. Throughput: one item per cycle while the
// receiver does not stall; the state update is combinational, set on a pop.
// When the receiver stalls, the output and the back pipeline hold; the front
// keeps taking items into a 4-entry queue and raises in_stall once it fills.
// Reset (rst, synchronous): both times, flags, stamps and the increment clear
// to zero, the pause guard returns to 200 ms and all pipelines empty.
module two_player_game_clock_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [tpgc_pkg::GUARD_W-1:0]  cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [2:0]                    req_type,
  input  logic [tpgc_pkg::TIME_W-1:0]   now_ms,
  input  logic                          pause_level,
  input  logic                          white_level,
  input  logic                          black_level,
  input  logic [tpgc_pkg::TIME_W-1:0]   base_ms,
  input  logic [tpgc_pkg::TIME_W-1:0]   increment_ms,
  input  logic [tpgc_pkg::TIME_W-1:0]   new_white_ms,
  input  logic [tpgc_pkg::TIME_W-1:0]   new_black_ms,
  input  logic                          write_white,
  input  logic                          write_black,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [tpgc_pkg::TIME_W-1:0]   white_left_ms,
  output logic [tpgc_pkg::TIME_W-1:0]   black_left_ms,
  output logic                          black_to_move,
  output logic                          is_paused,
  output logic                          is_running,
  output logic                          acknowledged,
  output logic                          state_report,
  output logic                          button_report,
  output logic [1:0]                    display_action,
  output logic [tpgc_pkg::DIGITS_W-1:0] white_digits,
  output logic [tpgc_pkg::DIGITS_W-1:0] black_digits
);

  logic              q_full;
  logic              q_empty;
  logic              push;
  logic              pop;
  logic              advance;
  logic              res_valid;
  tpgc_pkg::item_t   push_item;
  tpgc_pkg::item_t   head;
  tpgc_pkg::result_t res;

  // Accept and classify items
  tpgc_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .req_type     (req_type),
    .now_ms       (now_ms),
    .pause_level  (pause_level),
    .white_level  (white_level),
    .black_level  (black_level),
    .base_ms      (base_ms),
    .increment_ms (increment_ms),
    .new_white_ms (new_white_ms),
    .new_black_ms (new_black_ms),
    .write_white  (write_white),
    .write_black  (write_black),
    .q_full       (q_full),
    .push         (push),
    .push_item    (push_item)
  );

  // Decouple front and back
  tpgc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (head),
    .empty     (q_empty),
    .full      (q_full)
  );

  // Update the clock state
  tpgc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .head       (head),
    .head_valid (!q_empty),
    .advance    (advance),
    .pop        (pop),
    .res_valid  (res_valid),
    .res        (res)
  );

  // Convert times to display digits and drive the output
  tpgc_digits u_digits (
    .clk            (clk),
    .rst            (rst),
    .res_valid      (res_valid),
    .res            (res),
    .advance        (advance),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .white_left_ms  (white_left_ms),
    .black_left_ms  (black_left_ms),
    .black_to_move  (black_to_move),
    .is_paused      (is_paused),
    .is_running     (is_running),
    .acknowledged   (acknowledged),
    .state_report   (state_report),
    .button_report  (button_report),
    .display_action (display_action),
    .white_digits   (white_digits),
    .black_digits   (black_digits)
  );

endmodule

>>> sv/tpgc_queue.sv
`include "two_player_game_clock_unit_macros.svh"

module tpgc_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  tpgc_pkg::item_t   push_item,
  input  logic              pop,
  output tpgc_pkg::item_t   pop_item,
  output logic              empty,
  output logic              full
);

  tpgc_pkg::item_t                entries [tpgc_pkg::QUEUE_DEPTH];
  logic [tpgc_pkg::QPTR_W-1:0]    wr_ptr;
  logic [tpgc_pkg::QPTR_W-1:0]    rd_ptr;
  logic [tpgc_pkg::QPTR_W:0]      count;

  assign empty    = (count == '0);
  assign full     = (count == tpgc_pkg::QCOUNT_FULL);
  assign pop_item = entries[rd_ptr];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == tpgc_pkg::QPTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == tpgc_pkg::QPTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Store the incoming item
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  `TPGC_ASSERT_NOW(a_no_overflow, push, !full, "queue pushed while full")
  `TPGC_ASSERT_NOW(a_no_underflow, pop, !empty, "queue popped while empty")
  `TPGC_ASSERT_NOW(a_count_range, 1'b1, count <= tpgc_pkg::QCOUNT_FULL, "queue count out of range")

endmodule

>>> sv/tpgc_front.sv
module tpgc_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [2:0]                    req_type,
  input  logic [tpgc_pkg::TIME_W-1:0]   now_ms,
  input  logic                          pause_level,
  input  logic                          white_level,
  input  logic                          black_level,
  input  logic [tpgc_pkg::TIME_W-1:0]   base_ms,
  input  logic [tpgc_pkg::TIME_W-1:0]   increment_ms,
  input  logic [tpgc_pkg::TIME_W-1:0]   new_white_ms,
  input  logic [tpgc_pkg::TIME_W-1:0]   new_black_ms,
  input  logic                          write_white,
  input  logic                          write_black,
  input  logic                          q_full,
  output logic                          push,
  output tpgc_pkg::item_t               push_item
);

  logic                          adv;
  tpgc_pkg::kind_t               kind;
  tpgc_pkg::item_t               in_item;
  logic                          f1_valid;
  logic                          f2_valid;
  tpgc_pkg::item_t               f1_item;
  tpgc_pkg::item_t               f2_item;
  logic [63:0]                   f1_rep_prod;
  logic [63:0]                   f1_blk_prod;
  logic [tpgc_pkg::TIME_W-1:0]   f2_rep_qd;
  logic [tpgc_pkg::TIME_W-1:0]   f2_blk_q;
  logic [tpgc_pkg::TIME_W-1:0]   f2_blk_qd;
  logic                          rep_short;
  logic                          blk_short;

  // Move the two stages together unless the last one cannot drain
  assign adv      = !f2_valid || !q_full;
  assign in_stall = !adv;
  assign push     = f2_valid && !q_full;

  // Classify the request
  always_comb begin
    unique case (req_type)
      tpgc_pkg::REQ_TICK:   kind = tpgc_pkg::KIND_TICK;
      tpgc_pkg::REQ_RESET:  kind = tpgc_pkg::KIND_RESET;
      tpgc_pkg::REQ_SET:    kind = tpgc_pkg::KIND_SET;
      tpgc_pkg::REQ_PAUSE:  kind = tpgc_pkg::KIND_PAUSE;
      tpgc_pkg::REQ_RESUME: kind = tpgc_pkg::KIND_RESUME;
      default:              kind = tpgc_pkg::KIND_OTHER;
    endcase
  end

  // Pack the item, folding reset and set loads onto two shared fields
  always_comb begin
    in_item             = '0;
    in_item.kind        = kind;
    in_item.now_ms      = now_ms;
    in_item.pause_level = pause_level;
    in_item.white_level = white_level;
    in_item.black_level = black_level;
    in_item.val_a       = (kind == tpgc_pkg::KIND_RESET) ? base_ms : new_white_ms;
    in_item.val_b       = (kind == tpgc_pkg::KIND_RESET) ? increment_ms : new_black_ms;
    in_item.write_a     = write_white;
    in_item.write_b     = write_black;
  end

  // Track stage occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
      f2_valid <= 1'b0;
    end else if (adv) begin
      f1_valid <= in_valid;
      f2_valid <= f1_valid;
    end
  end

  // Stage 1 multiplies by the reciprocals, stage 2 forms quotient estimates
  always_ff @(posedge clk) begin
    if (adv) begin
      f1_item     <= in_item;
      f1_rep_prod <= 64'(now_ms) * tpgc_pkg::REPORT_MAGIC;
      f1_blk_prod <= 64'(now_ms) * tpgc_pkg::BLINK_MAGIC;
      f2_item     <= f1_item;
      f2_rep_qd   <= tpgc_pkg::cdiv_back(tpgc_pkg::cdiv_est(f1_rep_prod, tpgc_pkg::REPORT_SH),
                                         tpgc_pkg::REPORT_INTERVAL_MS);
      f2_blk_q    <= tpgc_pkg::cdiv_est(f1_blk_prod, tpgc_pkg::BLINK_SH);
      f2_blk_qd   <= tpgc_pkg::cdiv_back(tpgc_pkg::cdiv_est(f1_blk_prod, tpgc_pkg::BLINK_SH),
                                         tpgc_pkg::BLINK_HALF_MS);
    end
  end

  // Correct the estimates and fill in report mark and blink phase
  always_comb begin
    rep_short = tpgc_pkg::cdiv_short(f2_item.now_ms, f2_rep_qd, tpgc_pkg::REPORT_INTERVAL_MS);
    blk_short = tpgc_pkg::cdiv_short(f2_item.now_ms, f2_blk_qd, tpgc_pkg::BLINK_HALF_MS);
    push_item           = f2_item;
    push_item.mark_ms   = f2_rep_qd + (rep_short ? tpgc_pkg::REPORT_INTERVAL_V : '0);
    push_item.blink_odd = f2_blk_q[0] ^ blk_short;
  end

endmodule

>>> sv/tpgc_back.sv
`include "two_player_game_clock_unit_macros.svh"

module tpgc_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [tpgc_pkg::GUARD_W-1:0]  cfg_wdata,
  input  tpgc_pkg::item_t               head,
  input  logic                          head_valid,
  input  logic                          advance,
  output logic                          pop,
  output logic                          res_valid,
  output tpgc_pkg::result_t             res
);

  // Clock state
  logic [tpgc_pkg::TIME_W-1:0]  white_left, white_left_next;
  logic [tpgc_pkg::TIME_W-1:0]  black_left, black_left_next;
  logic                         turn_black, turn_black_next;
  logic                         running_flag, running_flag_next;
  logic                         paused_flag, paused_flag_next;
  logic [tpgc_pkg::TIME_W-1:0]  last_update_stamp, last_update_stamp_next;
  logic                         pause_held, pause_held_next;
  logic [tpgc_pkg::TIME_W-1:0]  pause_stamp, pause_stamp_next;
  logic [tpgc_pkg::TIME_W-1:0]  last_report_stamp, last_report_stamp_next;
  logic [tpgc_pkg::TIME_W-1:0]  bonus_ms, bonus_ms_next;
  logic                         white_button_seen, white_button_seen_next;
  logic                         black_button_seen, black_button_seen_next;
  logic [tpgc_pkg::GUARD_W-1:0] pause_guard_ms;

  logic [tpgc_pkg::TIME_W-1:0]  elapsed;
  logic [tpgc_pkg::TIME_W:0]    sum;
  logic                         done;
  logic                         mover;
  logic                         ack;
  logic                         srep;
  logic                         brep;
  logic [1:0]                   disp;
  tpgc_pkg::result_t            res_next;

  assign pop = head_valid && advance;

  // Work out the state after the head item
  always_comb begin
    white_left_next        = white_left;
    black_left_next        = black_left;
    turn_black_next        = turn_black;
    running_flag_next      = running_flag;
    paused_flag_next       = paused_flag;
    pause_held_next        = pause_held;
    pause_stamp_next       = pause_stamp;
    last_report_stamp_next = last_report_stamp;
    bonus_ms_next          = bonus_ms;
    white_button_seen_next = white_button_seen;
    black_button_seen_next = black_button_seen;
    elapsed                = '0;
    sum                    = '0;
    done                   = 1'b0;
    mover                  = 1'b0;
    ack                    = 1'b0;
    srep                   = 1'b0;
    brep                   = 1'b0;
    disp                   = tpgc_pkg::DISP_LEAVE;

    // Charge elapsed time to the side to move unless paused or never stamped
    last_update_stamp_next = head.now_ms;
    if (last_update_stamp != '0 && !paused_flag) begin
      elapsed = head.now_ms - last_update_stamp;
      if (turn_black) begin
        if (elapsed > black_left) begin
          black_left_next   = '0;
          running_flag_next = 1'b0;
        end else begin
          black_left_next = black_left - elapsed;
        end
      end else begin
        if (elapsed > white_left) begin
          white_left_next   = '0;
          running_flag_next = 1'b0;
        end else begin
          white_left_next = white_left - elapsed;
        end
      end
    end

    unique case (head.kind)
      tpgc_pkg::KIND_RESET: begin
        white_left_next   = head.val_a;
        black_left_next   = head.val_a;
        bonus_ms_next     = head.val_b;
        turn_black_next   = 1'b0;
        running_flag_next = 1'b1;
        ack               = 1'b1;
      end
      tpgc_pkg::KIND_SET: begin
        if (head.write_a) white_left_next = head.val_a;
        if (head.write_b) black_left_next = head.val_b;
        ack = 1'b1;
      end
      tpgc_pkg::KIND_PAUSE: begin
        paused_flag_next = 1'b1;
        ack              = 1'b1;
      end
      tpgc_pkg::KIND_RESUME: begin
        paused_flag_next = 1'b0;
        ack              = 1'b1;
      end
      tpgc_pkg::KIND_TICK: begin
        // Guarded pause button: toggle on a new press
        if (running_flag_next &&
            (head.now_ms - pause_stamp) > tpgc_pkg::TIME_W'(pause_guard_ms)) begin
          if (head.pause_level) begin
            if (!pause_held) begin
              pause_held_next        = 1'b1;
              paused_flag_next       = !paused_flag;
              pause_stamp_next       = head.now_ms;
              srep                   = 1'b1;
              last_report_stamp_next = head.mark_ms;
              done                   = 1'b1;
            end
          end else begin
            pause_held_next = 1'b0;
          end
        end
        if (!done) begin
          // Sample move buttons
          brep = (head.white_level != white_button_seen) ||
                 (head.black_level != black_button_seen);
          white_button_seen_next = head.white_level;
          black_button_seen_next = head.black_level;
          mover = turn_black ? head.black_level : head.white_level;
          if (mover) begin
            // Add the increment, saturating, and pass the turn
            if (turn_black) begin
              sum = {1'b0, black_left_next} + {1'b0, bonus_ms};
              black_left_next = sum[tpgc_pkg::TIME_W] ? '1 : sum[tpgc_pkg::TIME_W-1:0];
            end else begin
              sum = {1'b0, white_left_next} + {1'b0, bonus_ms};
              white_left_next = sum[tpgc_pkg::TIME_W] ? '1 : sum[tpgc_pkg::TIME_W-1:0];
            end
            turn_black_next        = !turn_black;
            srep                   = 1'b1;
            last_report_stamp_next = head.mark_ms;
          end else begin
            // Blink while stopped; the periodic report shows the times
            if (paused_flag || !running_flag_next) begin
              disp = head.blink_odd ? tpgc_pkg::DISP_BLANK : tpgc_pkg::DISP_SHOW;
            end
            if ((head.now_ms - last_report_stamp) >= tpgc_pkg::REPORT_INTERVAL_V) begin
              brep                   = 1'b1;
              srep                   = 1'b1;
              last_report_stamp_next = head.mark_ms;
              disp                   = tpgc_pkg::DISP_SHOW;
            end
          end
        end
      end
      tpgc_pkg::KIND_OTHER: begin
      end
      default: begin
      end
    endcase

    // Commands always report state
    if (ack) begin
      srep                   = 1'b1;
      last_report_stamp_next = head.mark_ms;
    end

    res_next.white_left_ms  = white_left_next;
    res_next.black_left_ms  = black_left_next;
    res_next.black_to_move  = turn_black_next;
    res_next.is_paused      = paused_flag_next;
    res_next.is_running     = running_flag_next;
    res_next.acknowledged   = ack;
    res_next.state_report   = srep;
    res_next.button_report  = brep;
    res_next.display_action = disp;
  end

  // Commit state on pop; take configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      white_left        <= '0;
      black_left        <= '0;
      turn_black        <= 1'b0;
      running_flag      <= 1'b0;
      paused_flag       <= 1'b0;
      last_update_stamp <= '0;
      pause_held        <= 1'b0;
      pause_stamp       <= '0;
      last_report_stamp <= '0;
      bonus_ms          <= '0;
      white_button_seen <= 1'b0;
      black_button_seen <= 1'b0;
      pause_guard_ms    <= tpgc_pkg::PAUSE_GUARD_RESET;
      res_valid         <= 1'b0;
    end else begin
      if (pop) begin
        white_left        <= white_left_next;
        black_left        <= black_left_next;
        turn_black        <= turn_black_next;
        running_flag      <= running_flag_next;
        paused_flag       <= paused_flag_next;
        last_update_stamp <= last_update_stamp_next;
        pause_held        <= pause_held_next;
        pause_stamp       <= pause_stamp_next;
        last_report_stamp <= last_report_stamp_next;
        bonus_ms          <= bonus_ms_next;
        white_button_seen <= white_button_seen_next;
        black_button_seen <= black_button_seen_next;
      end
      if (cfg_we) begin
        pause_guard_ms <= cfg_wdata;
      end
      if (advance) begin
        res_valid <= head_valid;
      end
    end
  end

  // Hold the result register for the digit pipeline
  always_ff @(posedge clk) begin
    if (pop) begin
      res <= res_next;
    end
  end

  `TPGC_ASSERT_NEXT(a_res_hold, res_valid && !advance, res_valid && $stable(res), "result changed while held")
  `TPGC_ASSERT_NOW(a_blank_quiet, res_valid && res.display_action == tpgc_pkg::DISP_BLANK, !res.state_report, "blank display with state report")

endmodule

>>> sv/tpgc_digits.sv
module tpgc_digits (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            res_valid,
  input  tpgc_pkg::result_t               res,
  output logic                            advance,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [tpgc_pkg::TIME_W-1:0]     white_left_ms,
  output logic [tpgc_pkg::TIME_W-1:0]     black_left_ms,
  output logic                            black_to_move,
  output logic                            is_paused,
  output logic                            is_running,
  output logic                            acknowledged,
  output logic                            state_report,
  output logic                            button_report,
  output logic [1:0]                      display_action,
  output logic [tpgc_pkg::DIGITS_W-1:0]   white_digits,
  output logic [tpgc_pkg::DIGITS_W-1:0]   black_digits
);

  logic                          v1, v2, v3;
  tpgc_pkg::result_t             r1, r2, r3;
  logic [63:0]                   s1_w_sec, s1_w_min, s1_b_sec, s1_b_min;
  logic [tpgc_pkg::TIME_W-1:0]   s2_w_sec_q, s2_w_sec_qd, s2_w_min_q, s2_w_min_qd;
  logic [tpgc_pkg::TIME_W-1:0]   s2_b_sec_q, s2_b_sec_qd, s2_b_min_q, s2_b_min_qd;
  logic [tpgc_pkg::TIME_W-1:0]   s3_w_sec, s3_w_min, s3_b_sec, s3_b_min;

  // Minutes (saturated) times one hundred plus seconds within the minute
  function automatic logic [tpgc_pkg::DIGITS_W-1:0] digits_of(
    logic [tpgc_pkg::TIME_W-1:0] q_sec,
    logic [tpgc_pkg::TIME_W-1:0] q_min
  );
    logic [tpgc_pkg::TIME_W-1:0]   secs;
    logic [tpgc_pkg::MIN_W-1:0]    mins;
    logic [tpgc_pkg::DIGITS_W-1:0] mins_ext;
    logic [tpgc_pkg::DIGITS_W-1:0] secs_ext;
    secs = q_sec - q_min * tpgc_pkg::TIME_W'(tpgc_pkg::SEC_PER_MIN);
    mins = (q_min > tpgc_pkg::TIME_W'(tpgc_pkg::MAX_MINUTES)) ?
           tpgc_pkg::MAX_MINUTES_V : q_min[tpgc_pkg::MIN_W-1:0];
    mins_ext = {{(tpgc_pkg::DIGITS_W - tpgc_pkg::MIN_W){1'b0}}, mins};
    secs_ext = {{(tpgc_pkg::DIGITS_W - tpgc_pkg::SEC_W){1'b0}}, secs[tpgc_pkg::SEC_W-1:0]};
    return mins_ext * tpgc_pkg::DIGITS_PER_MIN_V + secs_ext;
  endfunction

  // Move the whole pipeline unless the output item is held
  assign advance = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      v1        <= res_valid;
      v2        <= v1;
      v3        <= v2;
      out_valid <= v3;
    end
  end

  // Divide both times by a second and a minute, then build the digits
  always_ff @(posedge clk) begin
    if (advance) begin
      // Reciprocal products
      r1       <= res;
      s1_w_sec <= 64'(res.white_left_ms) * tpgc_pkg::SEC_MAGIC;
      s1_w_min <= 64'(res.white_left_ms) * tpgc_pkg::MIN_MAGIC;
      s1_b_sec <= 64'(res.black_left_ms) * tpgc_pkg::SEC_MAGIC;
      s1_b_min <= 64'(res.black_left_ms) * tpgc_pkg::MIN_MAGIC;

      // Quotient estimates and their back products
      r2          <= r1;
      s2_w_sec_q  <= tpgc_pkg::cdiv_est(s1_w_sec, tpgc_pkg::SEC_SH);
      s2_w_sec_qd <= tpgc_pkg::cdiv_back(tpgc_pkg::cdiv_est(s1_w_sec, tpgc_pkg::SEC_SH),
                                         tpgc_pkg::MS_PER_SEC);
      s2_w_min_q  <= tpgc_pkg::cdiv_est(s1_w_min, tpgc_pkg::MIN_SH);
      s2_w_min_qd <= tpgc_pkg::cdiv_back(tpgc_pkg::cdiv_est(s1_w_min, tpgc_pkg::MIN_SH),
                                         tpgc_pkg::MS_PER_MIN);
      s2_b_sec_q  <= tpgc_pkg::cdiv_est(s1_b_sec, tpgc_pkg::SEC_SH);
      s2_b_sec_qd <= tpgc_pkg::cdiv_back(tpgc_pkg::cdiv_est(s1_b_sec, tpgc_pkg::SEC_SH),
                                         tpgc_pkg::MS_PER_SEC);
      s2_b_min_q  <= tpgc_pkg::cdiv_est(s1_b_min, tpgc_pkg::MIN_SH);
      s2_b_min_qd <= tpgc_pkg::cdiv_back(tpgc_pkg::cdiv_est(s1_b_min, tpgc_pkg::MIN_SH),
                                         tpgc_pkg::MS_PER_MIN);

      // Correct estimates that fell one short
      r3       <= r2;
      s3_w_sec <= s2_w_sec_q + tpgc_pkg::TIME_W'(tpgc_pkg::cdiv_short(
                    r2.white_left_ms, s2_w_sec_qd, tpgc_pkg::MS_PER_SEC));
      s3_w_min <= s2_w_min_q + tpgc_pkg::TIME_W'(tpgc_pkg::cdiv_short(
                    r2.white_left_ms, s2_w_min_qd, tpgc_pkg::MS_PER_MIN));
      s3_b_sec <= s2_b_sec_q + tpgc_pkg::TIME_W'(tpgc_pkg::cdiv_short(
                    r2.black_left_ms, s2_b_sec_qd, tpgc_pkg::MS_PER_SEC));
      s3_b_min <= s2_b_min_q + tpgc_pkg::TIME_W'(tpgc_pkg::cdiv_short(
                    r2.black_left_ms, s2_b_min_qd, tpgc_pkg::MS_PER_MIN));

      // Output register
      white_left_ms  <= r3.white_left_ms;
      black_left_ms  <= r3.black_left_ms;
      black_to_move  <= r3.black_to_move;
      is_paused      <= r3.is_paused;
      is_running     <= r3.is_running;
      acknowledged   <= r3.acknowledged;
      state_report   <= r3.state_report;
      button_report  <= r3.button_report;
      display_action <= r3.display_action;
      white_digits   <= digits_of(s3_w_sec, s3_w_min);
      black_digits   <= digits_of(s3_b_sec, s3_b_min);
    end
  end

endmodule

>>> tb/sv/game_clock_checker.sv
`timescale 1ns / 100ps

module game_clock_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [tpgc_pkg::GUARD_W-1:0]  cfg_wdata,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [2:0]                    req_type,
  input  logic [tpgc_pkg::TIME_W-1:0]   now_ms,
  input  logic                          pause_level,
  input  logic                          white_level,
  input  logic                          black_level,
  input  logic [tpgc_pkg::TIME_W-1:0]   base_ms,
  input  logic [tpgc_pkg::TIME_W-1:0]   increment_ms,
  input  logic [tpgc_pkg::TIME_W-1:0]   new_white_ms,
  input  logic [tpgc_pkg::TIME_W-1:0]   new_black_ms,
  input  logic                          write_white,
  input  logic                          write_black,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [tpgc_pkg::TIME_W-1:0]   white_left_ms,
  input  logic [tpgc_pkg::TIME_W-1:0]   black_left_ms,
  input  logic                          black_to_move,
  input  logic                          is_paused,
  input  logic                          is_running,
  input  logic                          acknowledged,
  input  logic                          state_report,
  input  logic                          button_report,
  input  logic [1:0]                    display_action,
  input  logic [tpgc_pkg::DIGITS_W-1:0] white_digits,
  input  logic [tpgc_pkg::DIGITS_W-1:0] black_digits,
  output int                            views_owed,
  output int                            mismatch_total
);
  import tpgc_pkg::*;

  localparam int unsigned PRINT_CAP = 200;

  // Clock state as seen after one item
  typedef struct packed {
    logic [TIME_W-1:0]   white_ms;
    logic [TIME_W-1:0]   black_ms;
    logic                to_move;
    logic                paused;
    logic                running;
    logic                ack;
    logic                state_rep;
    logic                button_rep;
    logic [1:0]          display;
    logic [DIGITS_W-1:0] white_dig;
    logic [DIGITS_W-1:0] black_dig;
  } clock_view_t;

  // Predicted clock state
  logic [GUARD_W-1:0] guard_ms;
  logic [TIME_W-1:0]  white_ms, black_ms, bonus;
  logic [TIME_W-1:0]  stamp_ms, pause_toggle_ms, report_ms;
  logic               black_turn, running, paused, pause_down;
  logic               white_seen, black_seen;

  clock_view_t expected_views[$];
  int          errs = 0;
  int          results_seen = 0;

  function automatic logic [DIGITS_W-1:0] to_digits(logic [TIME_W-1:0] ms);
    int unsigned mins, secs;
    mins = ms / MS_PER_MIN;
    secs = (ms / MS_PER_SEC) % SEC_PER_MIN;
    if (mins > MAX_MINUTES) mins = MAX_MINUTES;
    return DIGITS_W'(mins * DIGITS_PER_MIN + secs);
  endfunction

  function automatic logic [TIME_W-1:0] report_floor(logic [TIME_W-1:0] t);
    return t - (t % REPORT_INTERVAL_MS);
  endfunction

  // Add the per-move bonus, pinned at the top of the range
  function automatic logic [TIME_W-1:0] add_bonus(logic [TIME_W-1:0] ms);
    logic [TIME_W:0] sum;
    sum = {1'b0, ms} + {1'b0, bonus};
    return sum[TIME_W] ? '1 : sum[TIME_W-1:0];
  endfunction

  // Advance the predicted clock by one item and return what it shows
  function automatic clock_view_t advance_clock(
    input logic [2:0]        req,
    input logic [TIME_W-1:0] now,
    input logic              p, w, b,
    input logic [TIME_W-1:0] base, inc, nw, nb,
    input logic              ww, wb
  );
    clock_view_t       v;
    logic [TIME_W-1:0] elapsed, since_toggle, since_report;
    logic              toggled, mover;
    v = '0;
    v.display = DISP_LEAVE;
    toggled = 1'b0;

    // Charge the side to move, unless paused or never stamped
    if (stamp_ms == '0 || paused) begin
      stamp_ms = now;
    end else begin
      elapsed = now - stamp_ms;
      stamp_ms = now;
      if (black_turn) begin
        if (elapsed > black_ms) begin
          black_ms = '0;
          running = 1'b0;
        end else begin
          black_ms = black_ms - elapsed;
        end
      end else begin
        if (elapsed > white_ms) begin
          white_ms = '0;
          running = 1'b0;
        end else begin
          white_ms = white_ms - elapsed;
        end
      end
    end

    case (req)
      REQ_RESET: begin
        white_ms = base;
        black_ms = base;
        bonus = inc;
        black_turn = 1'b0;
        running = 1'b1;
        v.ack = 1'b1;
      end
      REQ_SET: begin
        if (ww) white_ms = nw;
        if (wb) black_ms = nb;
        v.ack = 1'b1;
      end
      REQ_PAUSE: begin
        paused = 1'b1;
        v.ack = 1'b1;
      end
      REQ_RESUME: begin
        paused = 1'b0;
        v.ack = 1'b1;
      end
      REQ_TICK: begin
        // Guarded pause button; a fresh press ends the item
        since_toggle = now - pause_toggle_ms;
        if (running && since_toggle > TIME_W'(guard_ms)) begin
          if (!p) begin
            pause_down = 1'b0;
          end else if (!pause_down) begin
            pause_down = 1'b1;
            paused = !paused;
            pause_toggle_ms = now;
            v.state_rep = 1'b1;
            report_ms = report_floor(now);
            toggled = 1'b1;
          end
        end
        if (!toggled) begin
          v.button_rep = (w != white_seen) || (b != black_seen);
          white_seen = w;
          black_seen = b;
          mover = black_turn ? b : w;
          if (mover) begin
            // Move: add the bonus and pass the turn, even when paused or stopped
            if (black_turn) black_ms = add_bonus(black_ms);
            else white_ms = add_bonus(white_ms);
            black_turn = !black_turn;
            v.state_rep = 1'b1;
            report_ms = report_floor(now);
          end else begin
            // Blink while stopped; the periodic report shows the times
            if (paused || !running)
              v.display = ((now / BLINK_HALF_MS) % 2 == 0) ? DISP_SHOW : DISP_BLANK;
            since_report = now - report_ms;
            if (since_report >= REPORT_INTERVAL_MS) begin
              v.button_rep = 1'b1;
              v.state_rep = 1'b1;
              report_ms = report_floor(now);
              v.display = DISP_SHOW;
            end
          end
        end
      end
      default: ;
    endcase

    if (v.ack) begin
      v.state_rep = 1'b1;
      report_ms = report_floor(now);
    end

    v.white_ms  = white_ms;
    v.black_ms  = black_ms;
    v.to_move   = black_turn;
    v.paused    = paused;
    v.running   = running;
    v.white_dig = to_digits(white_ms);
    v.black_dig = to_digits(black_ms);
    return v;
  endfunction

  task automatic report_mismatch(input string msg);
    errs++;
    if (errs <= PRINT_CAP) $display("%0t ns: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [TIME_W-1:0] got,
                             input logic [TIME_W-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s: got %0h, expected %0h",
                                results_seen, name, got, want));
  endtask

  // Track items in, compare results out
  always @(posedge clk) begin
    clock_view_t want;
    if (rst) begin
      guard_ms        = PAUSE_GUARD_RESET;
      white_ms        = '0;
      black_ms        = '0;
      bonus           = '0;
      stamp_ms        = '0;
      pause_toggle_ms = '0;
      report_ms       = '0;
      black_turn      = 1'b0;
      running         = 1'b0;
      paused          = 1'b0;
      pause_down      = 1'b0;
      white_seen      = 1'b0;
      black_seen      = 1'b0;
      expected_views.delete();
    end else begin
      if (cfg_we) guard_ms = cfg_wdata;
      if (in_valid && !in_stall)
        expected_views.push_back(advance_clock(req_type, now_ms, pause_level,
          white_level, black_level, base_ms, increment_ms, new_white_ms,
          new_black_ms, write_white, write_black));
      if (out_valid && !out_stall) begin
        if (expected_views.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with no item outstanding",
                                    results_seen));
        end else begin
          want = expected_views.pop_front();
          check_field("white_left_ms", white_left_ms, want.white_ms);
          check_field("black_left_ms", black_left_ms, want.black_ms);
          check_field("black_to_move", black_to_move, want.to_move);
          check_field("is_paused", is_paused, want.paused);
          check_field("is_running", is_running, want.running);
          check_field("acknowledged", acknowledged, want.ack);
          check_field("state_report", state_report, want.state_rep);
          check_field("button_report", button_report, want.button_rep);
          check_field("display_action", display_action, want.display);
          check_field("white_digits", white_digits, want.white_dig);
          check_field("black_digits", black_digits, want.black_dig);
        end
        results_seen++;
      end
    end
    views_owed     <= expected_views.size();
    mismatch_total <= errs;
  end

endmodule

>>> tb/sv/tb_two_player_game_clock_unit.sv
`timescale 1ns / 100ps

module tb_two_player_game_clock_unit;
  import tpgc_pkg::*;

  localparam int unsigned QUIET_LIMIT = 5000;
  localparam int unsigned PHASE_ITEMS = 290;
  localparam int unsigned PHASES      = 5;
  // Request codes the block does not define
  localparam logic [2:0]  REQ_SPARE_FIRST = 3'd5;
  localparam logic [2:0]  REQ_SPARE_LAST  = 3'd7;

  typedef struct packed {
    logic [2:0]        req;
    logic [TIME_W-1:0] now;
    logic              p, w, b;
    logic [TIME_W-1:0] base, inc, nw, nb;
    logic              ww, wb;
  } clock_req_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [GUARD_W-1:0] cfg_wdata;
  logic in_valid, in_stall;
  logic [2:0] req_type;
  logic [TIME_W-1:0] now_ms, base_ms, increment_ms, new_white_ms, new_black_ms;
  logic pause_level, white_level, black_level, write_white, write_black;
  logic out_valid, out_stall;
  logic [TIME_W-1:0] white_left_ms, black_left_ms;
  logic black_to_move, is_paused, is_running, acknowledged;
  logic state_report, button_report;
  logic [1:0] display_action;
  logic [DIGITS_W-1:0] white_digits, black_digits;

  int views_owed, mismatch_total;
  logic calm;
  int unsigned stall_run = 0;
  int unsigned quiet_cycles = 0;
  int unsigned items_sent;
  logic [TIME_W-1:0] clock_ms;
  logic [GUARD_W-1:0] phase_guard [PHASES];

  always #10 clk = ~clk;

  two_player_game_clock_unit DUT (.*);

  game_clock_checker u_clock_check (.*);

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [TIME_W-1:0] pick_time();
    case ($urandom_range(0, 9))
      0:       return '0;
      1, 2:    return $urandom;
      3, 4, 5: return $urandom_range(5000, 7_200_000);
      default: return $urandom_range(200, 5000);
    endcase
  endfunction

  function automatic logic [TIME_W-1:0] pick_bonus();
    case ($urandom_range(0, 9))
      0, 1, 2:    return '0;
      3, 4, 5, 6: return $urandom_range(0, 10000);
      7, 8:       return $urandom;
      default:    return '1 - $urandom_range(0, 1000);
    endcase
  endfunction

  // Fields the request does not use carry random values
  function automatic clock_req_t blank_req(logic [2:0] req, logic [TIME_W-1:0] t);
    clock_req_t r;
    r.req  = req;
    r.now  = t;
    r.p    = 1'($urandom_range(0, 1));
    r.w    = 1'($urandom_range(0, 1));
    r.b    = 1'($urandom_range(0, 1));
    r.base = $urandom;
    r.inc  = $urandom;
    r.nw   = $urandom;
    r.nb   = $urandom;
    r.ww   = 1'($urandom_range(0, 1));
    r.wb   = 1'($urandom_range(0, 1));
    return r;
  endfunction

  function automatic clock_req_t make_tick(logic [TIME_W-1:0] t, logic p, logic w, logic b);
    clock_req_t r;
    r = blank_req(REQ_TICK, t);
    r.p = p;
    r.w = w;
    r.b = b;
    return r;
  endfunction

  function automatic clock_req_t make_reset(logic [TIME_W-1:0] t, logic [TIME_W-1:0] base,
                                            logic [TIME_W-1:0] inc);
    clock_req_t r;
    r = blank_req(REQ_RESET, t);
    r.base = base;
    r.inc = inc;
    return r;
  endfunction

  function automatic clock_req_t make_set(logic [TIME_W-1:0] t, logic ww,
                                          logic [TIME_W-1:0] nw, logic wb,
                                          logic [TIME_W-1:0] nb);
    clock_req_t r;
    r = blank_req(REQ_SET, t);
    r.ww = ww;
    r.nw = nw;
    r.wb = wb;
    r.nb = nb;
    return r;
  endfunction

  // Present one item and hold it until taken
  task automatic send_item(input clock_req_t r);
    in_valid     <= 1'b1;
    req_type     <= r.req;
    now_ms       <= r.now;
    pause_level  <= r.p;
    white_level  <= r.w;
    black_level  <= r.b;
    base_ms      <= r.base;
    increment_ms <= r.inc;
    new_white_ms <= r.nw;
    new_black_ms <= r.nb;
    write_white  <= r.ww;
    write_black  <= r.wb;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic idle_gap(input int unsigned n);
    if (n != 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Hold the sender until every result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (views_owed != 0);
  endtask

  task automatic write_guard(input logic [GUARD_W-1:0] value);
    drain_results();
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // One game: usually a reset, then mostly ticks with the odd command
  task automatic play_session();
    int unsigned len, step_max, r;
    logic fast;
    clock_req_t q;
    fast = ($urandom_range(0, 4) == 0);
    calm <= ($urandom_range(0, 3) == 0);
    case ($urandom_range(0, 7))
      0:       clock_ms = $urandom;
      1:       clock_ms = '1 - $urandom_range(0, 5000);
      default: ;
    endcase
    case ($urandom_range(0, 3))
      0:       step_max = 5;
      1:       step_max = 60;
      2:       step_max = 400;
      default: step_max = 1500;
    endcase
    if ($urandom_range(0, 7) != 0) begin
      clock_ms += $urandom_range(0, step_max);
      send_item(make_reset(clock_ms, pick_time(), pick_bonus()));
      idle_gap(fast ? 0 : pick_gap());
    end
    len = $urandom_range(10, 60);
    repeat (len) begin
      r = $urandom_range(0, 99);
      clock_ms += $urandom_range(0, step_max);
      if (r == 99) clock_ms = ($urandom_range(0, 1) != 0) ? $urandom : '0;
      if (r < 88)
        q = make_tick(clock_ms, $urandom_range(0, 7) == 0, $urandom_range(0, 5) == 0,
                      $urandom_range(0, 5) == 0);
      else if (r < 91)
        q = make_set(clock_ms, 1'($urandom_range(0, 1)), pick_time(),
                     1'($urandom_range(0, 1)), pick_time());
      else if (r < 93)
        q = blank_req(REQ_PAUSE, clock_ms);
      else if (r < 95)
        q = blank_req(REQ_RESUME, clock_ms);
      else if (r < 97)
        q = make_reset(clock_ms, pick_time(), pick_bonus());
      else
        q = blank_req(3'($urandom_range(REQ_SPARE_FIRST, REQ_SPARE_LAST)), clock_ms);
      send_item(q);
      idle_gap(fast ? 0 : pick_gap());
    end
  endtask

  // Receiver stalls in runs, switched off in calm stretches
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_run <= 0;
    end else if (stall_run != 0) begin
      stall_run <= stall_run - 1;
    end else begin
      out_stall <= !calm && ($urandom_range(0, 1) != 0);
      stall_run <= pick_gap();
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned target;
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    in_valid     = 1'b0;
    req_type     = REQ_TICK;
    now_ms       = '0;
    pause_level  = 1'b0;
    white_level  = 1'b0;
    black_level  = 1'b0;
    base_ms      = '0;
    increment_ms = '0;
    new_white_ms = '0;
    new_black_ms = '0;
    write_white  = 1'b0;
    write_black  = 1'b0;
    calm         = 1'b0;
    clock_ms     = '0;
    items_sent   = 0;
    phase_guard[0] = '0;
    phase_guard[1] = '1;
    phase_guard[2] = 16'd1;
    phase_guard[3] = 16'($urandom_range(2, 1000));
    phase_guard[4] = PAUSE_GUARD_RESET;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: before any game the first stamp is only taken
    send_item(make_tick(32'd0, 1'b0, 1'b0, 1'b0));
    send_item(make_reset(32'd1000, 32'd3000, 32'd500));
    // White moves, then keeps the button held with black to move
    send_item(make_tick(32'd1100, 1'b0, 1'b1, 1'b0));
    send_item(make_tick(32'd1150, 1'b0, 1'b1, 1'b0));
    // Pause press ends the item before the move buttons are looked at
    send_item(make_tick(32'd1500, 1'b1, 1'b0, 1'b1));
    // Held pause does not toggle again; black moves while paused
    send_item(make_tick(32'd1600, 1'b1, 1'b0, 1'b1));
    // Paused: blink, and the periodic report shows the times
    send_item(make_tick(32'd2700, 1'b0, 1'b0, 1'b0));
    send_item(make_tick(32'd2800, 1'b0, 1'b0, 1'b0));
    send_item(blank_req(REQ_RESUME, 32'd2900));
    send_item(blank_req(REQ_PAUSE, 32'd3000));
    send_item(blank_req(REQ_RESUME, 32'd3100));
    send_item(make_set(32'd3200, 1'b1, 32'hFFFF_FFF0, 1'b0, 32'd0));
    // Increment that overflows the white time
    send_item(make_reset(32'd3300, 32'hFFFF_FF00, 32'hFFFF_FFFF));
    send_item(make_tick(32'd3310, 1'b0, 1'b1, 1'b0));
    // Undefined request codes only charge time
    for (int k = REQ_SPARE_FIRST; k <= REQ_SPARE_LAST; k++)
      send_item(blank_req(3'(k), 32'd3400 + 32'(k)));
    send_item(make_set(32'd3500, 1'b1, 32'd50, 1'b1, 32'd50));
    // Black runs out; time is still charged while stopped
    send_item(make_tick(32'd3600, 1'b0, 1'b0, 1'b0));
    send_item(make_tick(32'd5000, 1'b0, 1'b0, 1'b0));
    send_item(make_tick(32'd5250, 1'b0, 1'b0, 1'b0));
    // Move while stopped
    send_item(make_tick(32'd5600, 1'b0, 1'b0, 1'b1));
    // Zero stamp, then the top of the range, then a wrap
    send_item(make_tick(32'd0, 1'b0, 1'b0, 1'b0));
    send_item(make_tick(32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0));
    send_item(make_reset(32'd5, 32'hFFFF_FFFF, 32'd0));
    send_item(make_tick(32'd16, 1'b1, 1'b1, 1'b1));
    send_item(make_set(32'd20, 1'b0, 32'd0, 1'b1, 32'hFFFF_FFFF));
    send_item(make_tick(32'd32, 1'b0, 1'b0, 1'b0));

    // Random games under several pause guards
    clock_ms = 32'd10000;
    for (int ph = 0; ph < PHASES; ph++) begin
      write_guard(phase_guard[ph]);
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) play_session();
    end

    drain_results();
    repeat (12) @(posedge clk);
    if (mismatch_total == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

>>> sim.f
+incdir+sv
sv/tpgc_pkg.sv
sv/tpgc_queue.sv
sv/tpgc_front.sv
sv/tpgc_back.sv
sv/tpgc_digits.sv
sv/two_player_game_clock_unit.sv
tb/sv/game_clock_checker.sv
tb/sv/tb_two_player_game_clock_unit.sv
